// ===== src/advtlv_pkg.sv =====
// Shared types, constants and helper functions for the advertising data TLV parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package advtlv_pkg;

    // Longest payload that is tracked; longer lengths are clamped on the first byte
    localparam int MAX_PAYLOAD_LEN = 255;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 160;
    localparam int M_TUSER_W = 4;

    // Record types that the parser acts on
    localparam logic [7:0] AD_UUID16_INC  = 8'h02;
    localparam logic [7:0] AD_UUID16_CMP  = 8'h03;
    localparam logic [7:0] AD_UUID32_INC  = 8'h04;
    localparam logic [7:0] AD_UUID32_CMP  = 8'h05;
    localparam logic [7:0] AD_UUID128_INC = 8'h06;
    localparam logic [7:0] AD_UUID128_CMP = 8'h07;
    localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
    localparam logic [7:0] AD_NAME_FULL   = 8'h09;
    localparam logic [7:0] AD_TX_POWER    = 8'h0A;
    localparam logic [7:0] AD_SVC_DATA16  = 8'h16;
    localparam logic [7:0] AD_APPEARANCE  = 8'h19;
    localparam logic [7:0] AD_SVC_DATA32  = 8'h20;
    localparam logic [7:0] AD_SVC_DATA128 = 8'h21;
    localparam logic [7:0] AD_MFG_DATA    = 8'hFF;

    // Presence flag bit positions
    localparam int FLAG_NAME = 0;
    localparam int FLAG_TX   = 1;
    localparam int FLAG_APP  = 2;
    localparam int FLAG_MFG  = 3;

    localparam logic signed [7:0] POWER_RESET = -8'sd128;

    // Input item kind
    localparam logic ITEM_BYTE  = 1'b0;
    localparam logic ITEM_CLEAR = 1'b1;

    // UUID size codes
    localparam logic [1:0] USIZE_16  = 2'd0;
    localparam logic [1:0] USIZE_32  = 2'd1;
    localparam logic [1:0] USIZE_128 = 2'd2;

    typedef enum logic [3:0] {
        RK_UUID       = 4'd0,
        RK_NAME_START = 4'd1,
        RK_NAME_BYTE  = 4'd2,
        RK_TX_POWER   = 4'd3,
        RK_APPEARANCE = 4'd4,
        RK_SVC_UUID   = 4'd5,
        RK_SVC_BYTE   = 4'd6,
        RK_MFG_START  = 4'd7,
        RK_MFG_BYTE   = 4'd8,
        RK_SUMMARY    = 4'd9
    } result_kind_t;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       first_byte;
        logic [7:0] payload_len;
    } item_t;

    typedef struct packed {
        result_kind_t      kind;
        logic [1:0]        uuid_size;
        logic [63:0]       value_low;
        logic [63:0]       value_high;
        logic [3:0]        flags;
        logic signed [7:0] tx_power;
        logic [15:0]       appearance;
    } result_t;

    // Up to two results caused by one input item
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } res_pair_t;

    // Byte lane mask of a UUID group: 1, 3 or 15; zero for types without a UUID
    function automatic logic [3:0] uuid_mask(input logic [7:0] rtype);
        logic [3:0] m;
        m = 4'd0;
        unique case (rtype)
            AD_UUID16_INC, AD_UUID16_CMP, AD_SVC_DATA16:    m = 4'd1;
            AD_UUID32_INC, AD_UUID32_CMP, AD_SVC_DATA32:    m = 4'd3;
            AD_UUID128_INC, AD_UUID128_CMP, AD_SVC_DATA128: m = 4'd15;
            default:                                        m = 4'd0;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] uuid_size_code(input logic [3:0] mask);
        logic [1:0] c;
        c = USIZE_128;
        if (mask == 4'd1) begin
            c = USIZE_16;
        end else if (mask == 4'd3) begin
            c = USIZE_32;
        end
        return c;
    endfunction

    // Merge one byte into the 128-bit UUID accumulator; lane 0 starts a new group
    function automatic logic [127:0] uuid_collect(input logic [127:0] acc,
                                                  input logic [3:0]   lane,
                                                  input logic [7:0]   b);
        logic [127:0] r;
        r = (lane == 4'd0) ? 128'd0 : acc;
        r[{lane, 3'b000} +: 8] = r[{lane, 3'b000} +: 8] | b;
        return r;
    endfunction

endpackage

// ===== src/advtlv_core.sv =====
// Parser state and the per-byte record decode: builds up to two results per item.
// Depends on advtlv_pkg.
`timescale 1ns / 1ps

module advtlv_core
    import advtlv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  item_t     item,
    input  logic      commit,
    output res_pair_t pair
);

    logic [7:0]        pos_reg,   pos_next;
    logic [7:0]        len_reg,   len_next;
    logic [7:0]        rem_reg,   rem_next;
    phase_t            phase_reg, phase_next;
    logic [7:0]        type_reg,  type_next;
    logic [7:0]        off_reg,   off_next;
    logic [127:0]      acc_reg,   acc_next;
    logic              stop_reg,  stop_next;
    logic [3:0]        flags_reg, flags_next;
    logic signed [7:0] power_reg, power_next;
    logic [15:0]       app_reg,   app_next;

    // State registers, updated only when the item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            phase_reg <= PH_LEN;
            type_reg  <= '0;
            off_reg   <= '0;
            acc_reg   <= '0;
            stop_reg  <= 1'b0;
            flags_reg <= '0;
            power_reg <= POWER_RESET;
            app_reg   <= '0;
        end else if (commit) begin
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
            type_reg  <= type_next;
            off_reg   <= off_next;
            acc_reg   <= acc_next;
            stop_reg  <= stop_next;
            flags_reg <= flags_next;
            power_reg <= power_next;
            app_reg   <= app_next;
        end
    end

    // Record walk and result decode
    always_comb begin
        logic [7:0]   b;
        logic [8:0]   rec_end;
        logic [7:0]   dlen;
        logic [7:0]   rem_dec;
        logic [3:0]   umask;
        logic [3:0]   lane;
        logic [127:0] acc_upd;
        logic         rec_v;
        logic         sum_v;
        result_kind_t rec_kind;
        logic [1:0]   rec_size;
        logic [63:0]  rec_lo;
        logic [63:0]  rec_hi;
        result_t      rec_res;
        result_t      sum_res;

        b        = item.data_byte;
        rec_end  = '0;
        dlen     = '0;
        rem_dec  = '0;
        umask    = uuid_mask(type_reg);
        lane     = '0;
        acc_upd  = acc_reg;
        rec_v    = 1'b0;
        sum_v    = 1'b0;
        rec_kind = RK_UUID;
        rec_size = USIZE_16;
        rec_lo   = '0;
        rec_hi   = '0;

        pos_next   = pos_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        type_next  = type_reg;
        off_next   = off_reg;
        acc_next   = acc_reg;
        stop_next  = stop_reg;
        flags_next = flags_reg;
        power_next = power_reg;
        app_next   = app_reg;

        if (item.kind == ITEM_CLEAR) begin
            flags_next = '0;
            power_next = POWER_RESET;
            app_next   = '0;
        end else begin
            // New payload restarts the walk
            if (item.first_byte) begin
                len_next   = (item.payload_len > 8'(MAX_PAYLOAD_LEN)) ?
                             8'(MAX_PAYLOAD_LEN) : item.payload_len;
                pos_next   = '0;
                phase_next = PH_LEN;
                rem_next   = '0;
                stop_next  = 1'b0;
            end

            if (pos_next < len_next) begin
                if (!stop_next) begin
                    unique case (phase_next)
                        PH_LEN: begin
                            rec_end = {1'b0, pos_next} + 9'd1 + {1'b0, b};
                            if (b == 8'd0 || rec_end > {1'b0, len_next}) begin
                                stop_next = 1'b1;
                            end else begin
                                rem_next   = b;
                                phase_next = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            dlen      = rem_next - 8'd1;
                            type_next = b;
                            off_next  = '0;
                            rem_next  = dlen;
                            if (b == AD_NAME_SHORT || b == AD_NAME_FULL) begin
                                flags_next[FLAG_NAME] = 1'b1;
                                rec_v    = 1'b1;
                                rec_kind = RK_NAME_START;
                                rec_lo   = {56'd0, dlen};
                            end else if (b == AD_MFG_DATA) begin
                                flags_next[FLAG_MFG] = 1'b1;
                                rec_v    = 1'b1;
                                rec_kind = RK_MFG_START;
                                rec_lo   = {56'd0, dlen};
                            end
                            phase_next = (dlen == 8'd0) ? PH_LEN : PH_DATA;
                        end
                        PH_DATA: begin
                            priority if (type_reg >= AD_UUID16_INC &&
                                         type_reg <= AD_UUID128_CMP) begin
                                // UUID list: complete groups only
                                lane     = off_reg[3:0] & umask;
                                acc_upd  = uuid_collect(acc_reg, lane, b);
                                acc_next = acc_upd;
                                if (lane == umask) begin
                                    rec_v    = 1'b1;
                                    rec_kind = RK_UUID;
                                    rec_size = uuid_size_code(umask);
                                    rec_lo   = acc_upd[63:0];
                                    rec_hi   = (umask == 4'd15) ? acc_upd[127:64] : 64'd0;
                                end
                            end else if (type_reg == AD_SVC_DATA16 ||
                                         type_reg == AD_SVC_DATA32 ||
                                         type_reg == AD_SVC_DATA128) begin
                                // Service data: UUID first, then data bytes
                                if (off_reg <= {4'd0, umask}) begin
                                    lane     = off_reg[3:0];
                                    acc_upd  = uuid_collect(acc_reg, lane, b);
                                    acc_next = acc_upd;
                                    if (lane == umask) begin
                                        rec_v    = 1'b1;
                                        rec_kind = RK_SVC_UUID;
                                        rec_size = uuid_size_code(umask);
                                        rec_lo   = acc_upd[63:0];
                                        rec_hi   = (umask == 4'd15) ?
                                                   acc_upd[127:64] : 64'd0;
                                    end
                                end else begin
                                    rec_v    = 1'b1;
                                    rec_kind = RK_SVC_BYTE;
                                    rec_lo   = {56'd0, b};
                                end
                            end else if (type_reg == AD_NAME_SHORT ||
                                         type_reg == AD_NAME_FULL) begin
                                rec_v    = 1'b1;
                                rec_kind = RK_NAME_BYTE;
                                rec_lo   = {56'd0, b};
                            end else if (type_reg == AD_MFG_DATA) begin
                                rec_v    = 1'b1;
                                rec_kind = RK_MFG_BYTE;
                                rec_lo   = {56'd0, b};
                            end else if (type_reg == AD_TX_POWER) begin
                                if (off_reg == 8'd0) begin
                                    power_next          = b;
                                    flags_next[FLAG_TX] = 1'b1;
                                    rec_v    = 1'b1;
                                    rec_kind = RK_TX_POWER;
                                    rec_lo   = {56'd0, b};
                                end
                            end else if (type_reg == AD_APPEARANCE) begin
                                // Low byte parks in the accumulator until the high byte
                                if (off_reg == 8'd0) begin
                                    acc_next = {acc_reg[127:64], 56'd0, b};
                                end else if (off_reg == 8'd1) begin
                                    app_next             = {b, acc_reg[7:0]};
                                    flags_next[FLAG_APP] = 1'b1;
                                    rec_v    = 1'b1;
                                    rec_kind = RK_APPEARANCE;
                                    rec_lo   = {48'd0, b, acc_reg[7:0]};
                                end
                            end else begin
                                rec_v = 1'b0;
                            end
                            off_next = (off_reg == 8'hFF) ? off_reg : off_reg + 8'd1;
                            rem_dec  = rem_next - 8'd1;
                            rem_next = rem_dec;
                            if (rem_dec == 8'd0) begin
                                phase_next = PH_LEN;
                            end
                        end
                        default: begin
                            phase_next = PH_LEN;
                        end
                    endcase
                end

                pos_next = pos_next + 8'd1;
                sum_v    = (pos_next == len_next);
            end
        end

        // Results carry the flags and levels as they stand after this item
        rec_res.kind       = rec_kind;
        rec_res.uuid_size  = rec_size;
        rec_res.value_low  = rec_lo;
        rec_res.value_high = rec_hi;
        rec_res.flags      = flags_next;
        rec_res.tx_power   = power_next;
        rec_res.appearance = app_next;

        sum_res            = rec_res;
        sum_res.kind       = RK_SUMMARY;
        sum_res.uuid_size  = USIZE_16;
        sum_res.value_low  = '0;
        sum_res.value_high = '0;

        pair.count  = {1'b0, rec_v} + {1'b0, sum_v};
        pair.first  = rec_v ? rec_res : sum_res;
        pair.second = sum_res;
    end

endmodule

// ===== src/advtlv_outbuf.sv =====
// Result register: holds the results of one item and hands them out one per cycle while out_ready is high.
// Depends on advtlv_pkg.
`timescale 1ns / 1ps

module advtlv_outbuf
    import advtlv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  res_pair_t pair,
    output logic      free_next,
    output logic      out_valid,
    input  logic      out_ready,
    output result_t   out_res,
    output logic      out_last
);

    result_t    res_reg [2];
    logic [1:0] cnt_reg,  cnt_next;
    logic       head_reg, head_next;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_res   = res_reg[head_reg];
    assign out_last  = (cnt_reg == 2'd1);
    assign pop       = out_valid && out_ready;
    // Empty now, or the final result leaves this cycle
    assign free_next = (cnt_reg == 2'd0) || (pop && cnt_reg == 2'd1);

    // Count and read pointer
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = 1'b1;
        end
        if (load) begin
            cnt_next  = pair.count;
            head_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            head_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg[0] <= pair.first;
            res_reg[1] <= pair.second;
        end
    end

endmodule

// ===== src/adv_data_tlv_parser_unit.sv =====
// Advertising data TLV parser, top level: input register, decode core, result register.
// An accepted request passes the input register and then the result register before its first result is valid.
// Throughput: one request per cycle while m_axis_tready is high; a request that yields a record result
// and the payload summary holds the result register, and so the input, until both results have left.
// Reset: synchronous on aresetn low; parse state, flags, TX power (-128), appearance reset.
// Depends on advtlv_pkg, advtlv_core, advtlv_outbuf.
`timescale 1ns / 1ps

module adv_data_tlv_parser_unit
    import advtlv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // data_byte[7:0], first_byte[8], payload_len[16:9], zero fill
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // kind[0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // uuid_size[1:0], value_low[65:2], value_high[129:66], has_name[130],
    // has_tx_power[131], has_appearance[132], has_mfg_data[133],
    // tx_power[141:134], appearance_value[157:142], zero fill
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // result_kind[3:0]
    output logic [M_TUSER_W-1:0] m_axis_tuser,
    output logic                 m_axis_tlast
);

    item_t     item_reg;
    logic      in_valid_reg, in_valid_next;
    logic      proc_fire;
    logic      out_free;
    logic      s_fire;
    res_pair_t pair;
    result_t   out_res;

    // Item moves on when it makes no result or the result register frees up
    assign proc_fire     = in_valid_reg && ((pair.count == 2'd0) || out_free);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.kind        <= s_axis_tuser[0];
            item_reg.data_byte   <= s_axis_tdata[7:0];
            item_reg.first_byte  <= s_axis_tdata[8];
            item_reg.payload_len <= s_axis_tdata[16:9];
        end
    end

    advtlv_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .commit  (proc_fire),
        .pair    (pair)
    );

    advtlv_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc_fire && (pair.count != 2'd0)),
        .pair      (pair),
        .free_next (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    // Result packing
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {2'b00,
                           out_res.appearance,
                           out_res.tx_power,
                           out_res.flags[FLAG_MFG],
                           out_res.flags[FLAG_APP],
                           out_res.flags[FLAG_TX],
                           out_res.flags[FLAG_NAME],
                           out_res.value_high,
                           out_res.value_low,
                           out_res.uuid_size};

    // Checks
    a_summary_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == RK_SUMMARY) |-> m_axis_tlast)
        else $error("summary result not marked last");

    a_pair_second_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && pair.count == 2'd2) |-> (pair.second.kind == RK_SUMMARY))
        else $error("two results from one request without a trailing summary");

    a_pair_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> (pair.count != 2'd3))
        else $error("more than two results from one request");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_axis_tvalid && s_axis_tready))
        else $error("channels not empty after reset");

endmodule
